// File: design/wildcard_name_matcher_defines.svh
// Assertion macros for the wildcard name matcher.
// Used by the queue and back-end modules; needs clk and rst in scope.
`ifndef WILDCARD_NAME_MATCHER_DEFINES_SVH
`define WILDCARD_NAME_MATCHER_DEFINES_SVH

`ifndef SYNTHESIS
`define WNM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wnm assertion failed");
`define WNM_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("wnm reset assertion failed");
`else
`define WNM_ASSERT(label, prop)
`define WNM_ASSERT_RST(label, prop)
`endif

`endif

// File: design/wnm_pkg.sv
// Package for the wildcard name matcher: widths, register codes, types
// and the star closure function. No dependencies.
package wnm_pkg;

  localparam int PATTERN_MAX = 24;
  localparam int POS_W       = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int CHAR_W      = 16;
  localparam int WORD_CHARS  = 4;
  localparam int WORD_COUNT  = 6;
  localparam int CFG_DATA_W  = WORD_CHARS * CHAR_W;
  localparam int CFG_IDX_W   = 3;
  localparam int SCAN_LEVELS = $clog2(POS_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd1;

  localparam logic [CHAR_W-1:0] STAR_CHAR     = 16'h002A;
  localparam logic [CHAR_W-1:0] QUESTION_CHAR = 16'h003F;

  typedef logic [CHAR_W-1:0]      char_t;
  typedef logic [LEN_W-1:0]       len_t;
  typedef logic [POS_W-1:0]       pos_t;
  typedef logic [PATTERN_MAX-1:0] mask_t;
  typedef logic [PATTERN_MAX-1:0][CHAR_W-1:0] pat_chars_t;

  typedef struct packed {
    len_t  eff_len;
    mask_t len_mask;
    mask_t star_mask;
  } pat_ctl_t;

  typedef struct packed {
    mask_t hit;
    logic  last_char;
    logic  empty_name;
  } work_t;

  // Prefix OR along runs of stars: bit i+1 follows bit i where char i is '*'.
  function automatic pos_t close_stars(pos_t v, mask_t star);
    pos_t g;
    pos_t p;
    g = v;
    p = {star, 1'b0};
    for (int lvl = 0; lvl < SCAN_LEVELS; lvl++) begin
      g = g | (p & (g << (1 << lvl)));
      p = p & (p << (1 << lvl));
    end
    return g;
  endfunction

endpackage

// File: design/wnm_ifs.sv
// Channel interfaces for the wildcard name matcher: name characters,
// match results and configuration writes. Depends on wnm_pkg.
interface wnm_char_if;
  logic                 valid;
  logic                 ready;
  wnm_pkg::char_t       name_char;
  logic                 last_char;
  logic                 empty_name;
  modport source (output valid, name_char, last_char, empty_name, input ready);
  modport sink   (input valid, name_char, last_char, empty_name, output ready);
endinterface

interface wnm_result_if;
  logic valid;
  logic ready;
  logic matched;
  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

interface wnm_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [wnm_pkg::CFG_IDX_W-1:0]        index;
  logic [wnm_pkg::CFG_DATA_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/wnm_cfg.sv
// Pattern registers and derived length and star masks.
// Depends on wnm_pkg and wnm_ifs.
module wnm_cfg (
  input  logic                clk,
  input  logic                rst,
  wnm_cfg_if.sink             cfg,
  output wnm_pkg::pat_chars_t pattern,
  output wnm_pkg::pat_ctl_t   ctl
);
  import wnm_pkg::*;

  len_t pattern_length;
  len_t eff_len;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern        <= '0;
    end else if (cfg.valid) begin
      if (cfg.index == REG_PATTERN_LENGTH) begin
        pattern_length <= cfg.data[LEN_W-1:0];
      end
      for (int w = 0; w < WORD_COUNT; w++) begin
        if (cfg.index == CFG_IDX_W'(REG_PATTERN_WORD_0 + w)) begin
          pattern[w*WORD_CHARS +: WORD_CHARS] <= cfg.data;
        end
      end
    end
  end

  assign eff_len = (pattern_length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                          : pattern_length;

  always_comb begin
    ctl.eff_len = eff_len;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      ctl.len_mask[i]  = LEN_W'(i) < eff_len;
      ctl.star_mask[i] = ctl.len_mask[i] && (pattern[i] == STAR_CHAR);
    end
  end

endmodule

// File: design/wnm_front.sv
// Front end: accepts name characters and compares them against every
// pattern position. Depends on wnm_pkg and wnm_ifs.
module wnm_front (
  wnm_char_if.sink            chars,
  input  wnm_pkg::pat_chars_t pattern,
  input  wnm_pkg::pat_ctl_t   ctl,
  input  logic                full,
  output logic                push,
  output wnm_pkg::work_t      push_data
);
  import wnm_pkg::*;

  assign chars.ready = !full;
  assign push        = chars.valid && !full;

  always_comb begin
    push_data.last_char  = chars.last_char;
    push_data.empty_name = chars.empty_name;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      push_data.hit[i] = ctl.len_mask[i] && !ctl.star_mask[i] &&
                         ((pattern[i] == QUESTION_CHAR) || (pattern[i] == chars.name_char));
    end
  end

endmodule

// File: design/wnm_queue.sv
// Short FIFO between front and back ends.
// Depends on wnm_pkg and the assertion macro header.
`include "wildcard_name_matcher_defines.svh"
module wnm_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wnm_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output wnm_pkg::work_t head
);
  import wnm_pkg::*;

  work_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `WNM_ASSERT(a_count_bound, count <= QCNT_W'(QUEUE_DEPTH))
  `WNM_ASSERT(a_count_up, push && !pop |=> count == $past(count) + 1'b1)
  `WNM_ASSERT(a_count_down, pop && !push |=> count == $past(count) - 1'b1)

endmodule

// File: design/wnm_back.sv
// Back end: active position vector, star closure and result register.
// Depends on wnm_pkg, wnm_ifs and the assertion macro header.
`include "wildcard_name_matcher_defines.svh"
module wnm_back (
  input  logic              clk,
  input  logic              rst,
  input  wnm_pkg::pat_ctl_t ctl,
  input  logic              head_valid,
  input  wnm_pkg::work_t    head,
  output logic              pop,
  wnm_result_if.source      result
);
  import wnm_pkg::*;

  pos_t active;
  logic at_start;
  pos_t start_vec;
  pos_t cur;
  pos_t step_vec;
  pos_t next_vec;
  logic produces;
  logic matched_next;
  logic out_valid;
  logic out_matched;

  assign start_vec = close_stars(POS_W'(1), ctl.star_mask);
  assign cur       = at_start ? start_vec : active;
  assign step_vec  = {1'b0, cur[PATTERN_MAX-1:0] & ctl.star_mask} |
                     {cur[PATTERN_MAX-1:0] & head.hit, 1'b0};
  assign next_vec  = close_stars(step_vec, ctl.star_mask);

  assign produces     = head.last_char || head.empty_name;
  assign matched_next = head.empty_name ? start_vec[ctl.eff_len] : next_vec[ctl.eff_len];
  assign pop          = head_valid && (!produces || !out_valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        at_start <= produces;
      end
      if (pop && produces) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !produces) begin
      active <= next_vec;
    end
    if (pop && produces) begin
      out_matched <= matched_next;
    end
  end

  assign result.valid   = out_valid;
  assign result.matched = out_matched;

  `WNM_ASSERT_RST(a_reset_start, rst |=> at_start && !out_valid)
  `WNM_ASSERT(a_result_restarts, pop && produces |=> at_start)
  `WNM_ASSERT(a_result_from_pop, $rose(out_valid) |-> $past(pop))

endmodule

// File: design/wildcard_name_matcher.sv
// Wildcard name matcher, top level. One name character per cycle while the
// queue has room; a result passes through the queue to the output register.
// Rate is set by the combinational update of the 25-bit position vector.
// Synchronous reset clears the pattern registers to zero, empties the
// queue and returns the position vector to the start state.
// Depends on wnm_pkg, wnm_ifs, wnm_cfg, wnm_front, wnm_queue, wnm_back.
module wildcard_name_matcher (
  input  logic         clk,
  input  logic         rst,
  wnm_char_if.sink     chars,
  wnm_result_if.source result,
  wnm_cfg_if.sink      cfg
);
  import wnm_pkg::*;

  pat_chars_t pattern;
  pat_ctl_t   ctl;
  logic       full;
  logic       push;
  work_t      push_data;
  logic       pop;
  logic       head_valid;
  work_t      head;

  wnm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pattern (pattern),
    .ctl     (ctl)
  );

  wnm_front u_front (
    .chars     (chars),
    .pattern   (pattern),
    .ctl       (ctl),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  wnm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  wnm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule
